### hdl/ecc_pkg.sv
// Shared types and constants of the endurance cycle controller.
// Holds the beat layouts, mode codes and register map; depends on nothing.
`default_nettype none

package ecc_pkg;

	localparam int CFG_W       = 24;
	localparam int APB_AW      = 5;
	localparam int APB_DW      = 32;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 40;

	// Reset values of the timeout registers.
	localparam logic [CFG_W-1:0] FIRST_ONE_RST = CFG_W'(1500 * 60);
	localparam logic [CFG_W-1:0] FIRST_TWO_RST = CFG_W'(10000 * 60);
	localparam logic [CFG_W-1:0] RUN_WAIT_RST  = CFG_W'(1500 * 60);
	localparam logic [CFG_W-1:0] CHECK_TO_RST  = CFG_W'(10000 * 60);

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_FIRST = 3'd1,
		MODE_START = 3'd2,
		MODE_CHECK = 3'd3,
		MODE_ALARM = 3'd4,
		MODE_TOP   = 3'd5
	} mode_t;

	typedef enum logic {
		PHASE_ONE = 1'b0,
		PHASE_TWO = 1'b1
	} phase_t;

	typedef enum logic [2:0] {
		REG_FIRST_ONE = 3'd0,
		REG_FIRST_TWO = 3'd1,
		REG_RUN_WAIT  = 3'd2,
		REG_CHECK_TO  = 3'd3,
		REG_TOP_LIMIT = 3'd4,
		REG_PRESET    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] first_phase_one_ms;
		logic [CFG_W-1:0] first_phase_two_ms;
		logic [CFG_W-1:0] run_wait_ms;
		logic [CFG_W-1:0] check_timeout_ms;
		logic [CFG_W-1:0] top_limit;
		logic [CFG_W-1:0] preset_count;
	} cfg_t;

	// Listed from the highest bit down; tick sits in bit 0.
	typedef struct packed {
		logic feedback_level;
		logic preset_press;
		logic play_press;
		logic tick;
	} item_t;

	// Listed from the highest bit down; mode sits in bits 2:0.
	typedef struct packed {
		logic [CFG_W-1:0] cycle_count;
		logic             yellow_flash;
		logic             red_on;
		logic             green_flash;
		logic             buzzer_on;
		logic             restart_pulse;
		logic             drive_on;
		mode_t            mode;
	} result_t;

endpackage

`default_nettype wire

### hdl/ecc_cfg.sv
// Configuration register file of the endurance cycle controller on an APB port.
// Uses the register map and cfg_t from ecc_pkg.
`default_nettype none

module ecc_cfg (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [ecc_pkg::APB_AW-1:0]   paddr,
	input  wire  [ecc_pkg::APB_DW-1:0]   pwdata,
	output logic [ecc_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output ecc_pkg::cfg_t                cfg
);
	import ecc_pkg::*;

	cfg_t     cfg_q;
	cfg_reg_t idx;
	logic     wr_en;
	logic [CFG_W-1:0] wval;
	logic [CFG_W-1:0] rval;

	assign pready = 1'b1;
	assign idx    = cfg_reg_t'(paddr[APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign wval   = pwdata[CFG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_phase_one_ms <= FIRST_ONE_RST;
			cfg_q.first_phase_two_ms <= FIRST_TWO_RST;
			cfg_q.run_wait_ms        <= RUN_WAIT_RST;
			cfg_q.check_timeout_ms   <= CHECK_TO_RST;
			cfg_q.top_limit          <= '0;
			cfg_q.preset_count       <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_FIRST_ONE: cfg_q.first_phase_one_ms <= wval;
				REG_FIRST_TWO: cfg_q.first_phase_two_ms <= wval;
				REG_RUN_WAIT:  cfg_q.run_wait_ms        <= wval;
				REG_CHECK_TO:  cfg_q.check_timeout_ms   <= wval;
				REG_TOP_LIMIT: cfg_q.top_limit          <= wval;
				REG_PRESET:    cfg_q.preset_count       <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FIRST_ONE: rval = cfg_q.first_phase_one_ms;
			REG_FIRST_TWO: rval = cfg_q.first_phase_two_ms;
			REG_RUN_WAIT:  rval = cfg_q.run_wait_ms;
			REG_CHECK_TO:  rval = cfg_q.check_timeout_ms;
			REG_TOP_LIMIT: rval = cfg_q.top_limit;
			REG_PRESET:    rval = cfg_q.preset_count;
			default:       rval = '0;
		endcase
	end

	assign prdata = APB_DW'(rval);
	assign cfg    = cfg_q;

endmodule

`default_nettype wire

### hdl/ecc_core.sv
// Sequencer state and the one-pass update of the endurance cycle controller.
// Uses mode, item, result and cfg types from ecc_pkg.
`default_nettype none

module ecc_core #(
	parameter int COUNT_BITS = 24,
	parameter int TIMER_BITS = 25
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               adv,
	input  ecc_pkg::item_t    item,
	input  ecc_pkg::cfg_t     cfg,
	output ecc_pkg::result_t  result
);
	import ecc_pkg::*;

	localparam int TW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int CW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	mode_t                  mode_q, mode_n;
	phase_t                 phase_q, phase_n;
	logic                   armed_q, armed_n;
	logic                   drive_q, drive_n;
	logic [TIMER_BITS-1:0]  elapsed_q, elapsed_n;
	logic [COUNT_BITS-1:0]  cycles_q, cycles_n;
	logic                   pulse;
	logic                   stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			phase_q   <= PHASE_ONE;
			armed_q   <= 1'b0;
			drive_q   <= 1'b0;
			elapsed_q <= '0;
			cycles_q  <= '0;
		end else if (adv) begin
			mode_q    <= mode_n;
			phase_q   <= phase_n;
			armed_q   <= armed_n;
			drive_q   <= drive_n;
			elapsed_q <= elapsed_n;
			cycles_q  <= cycles_n;
		end
	end

	always_comb begin
		mode_n    = mode_q;
		phase_n   = phase_q;
		armed_n   = armed_q;
		drive_n   = drive_q;
		elapsed_n = elapsed_q;
		cycles_n  = cycles_q;
		pulse     = 1'b0;
		stop      = 1'b0;

		if (item.play_press)
			armed_n = (mode_q == MODE_IDLE);
		if (item.preset_press)
			cycles_n = COUNT_BITS'(cfg.preset_count);
		if (item.tick && elapsed_n != TIMER_MAX)
			elapsed_n = elapsed_n + 1'b1;

		case (mode_q)
			MODE_IDLE: begin
				if (armed_n) begin
					drive_n   = 1'b1;
					elapsed_n = '0;
					phase_n   = PHASE_ONE;
					mode_n    = MODE_FIRST;
				end
			end
			MODE_FIRST: begin
				if (phase_q == PHASE_ONE) begin
					if (TW'(elapsed_n) > TW'(cfg.first_phase_one_ms)) begin
						drive_n   = 1'b1;
						pulse     = 1'b1;
						phase_n   = PHASE_TWO;
						elapsed_n = '0;
					end
				end else if (TW'(elapsed_n) > TW'(cfg.first_phase_two_ms)) begin
					drive_n = 1'b0;
					mode_n  = MODE_ALARM;
					stop    = 1'b1;
				end
				if (!stop) begin
					if (!item.feedback_level) begin
						if (cycles_n != COUNT_MAX)
							cycles_n = cycles_n + 1'b1;
						if (CW'(cycles_n) >= CW'(cfg.top_limit)) begin
							drive_n = 1'b0;
							mode_n  = MODE_TOP;
						end else begin
							drive_n   = 1'b1;
							pulse     = 1'b1;
							elapsed_n = '0;
							mode_n    = MODE_START;
						end
					end
					if (!armed_n) begin
						drive_n = 1'b0;
						mode_n  = MODE_IDLE;
					end
				end
			end
			MODE_START: begin
				if (TW'(elapsed_n) > TW'(cfg.run_wait_ms)) begin
					drive_n   = 1'b1;
					pulse     = 1'b1;
					elapsed_n = '0;
					mode_n    = MODE_CHECK;
				end
				if (!armed_n) begin
					drive_n = 1'b0;
					mode_n  = MODE_IDLE;
				end
			end
			MODE_CHECK: begin
				if (!item.feedback_level) begin
					if (cycles_n != COUNT_MAX)
						cycles_n = cycles_n + 1'b1;
					if (CW'(cycles_n) >= CW'(cfg.top_limit)) begin
						drive_n = 1'b0;
						mode_n  = MODE_TOP;
					end else begin
						drive_n   = 1'b1;
						pulse     = 1'b1;
						elapsed_n = '0;
						mode_n    = MODE_START;
					end
				end
				// A count that reaches the top limit leaves the timer running, so the
				// timeout can still raise the alarm in the same pass.
				if (TW'(elapsed_n) > TW'(cfg.check_timeout_ms)) begin
					drive_n = 1'b0;
					mode_n  = MODE_ALARM;
				end
				if (!armed_n) begin
					drive_n = 1'b0;
					mode_n  = MODE_IDLE;
				end
			end
			MODE_ALARM, MODE_TOP: begin
				if (!armed_n)
					mode_n = MODE_IDLE;
			end
			default: ;
		endcase
	end

	always_comb begin
		result.mode          = mode_n;
		result.drive_on      = drive_n;
		result.restart_pulse = pulse;
		result.buzzer_on     = (mode_n == MODE_ALARM);
		result.green_flash   = (mode_n == MODE_FIRST) || (mode_n == MODE_START) ||
		                       (mode_n == MODE_CHECK);
		result.red_on        = (mode_n == MODE_ALARM);
		result.yellow_flash  = (mode_n == MODE_TOP);
		result.cycle_count   = CFG_W'(cycles_n);
	end

	// The drive is on exactly while a run is in progress.
	a_drive_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q == ((mode_q == MODE_FIRST) || (mode_q == MODE_START) ||
		            (mode_q == MODE_CHECK)))
		else $error("drive state disagrees with mode");

	// State moves only when a beat passes through the update.
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(mode_q) && $stable(elapsed_q) && $stable(cycles_q))
		else $error("state changed without an update");

	// The cycle counter saturates.
	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !item.preset_press && cycles_q == COUNT_MAX |=> cycles_q == COUNT_MAX)
		else $error("cycle counter wrapped");

	// A restart is never requested in the pass that raises the alarm.
	a_pulse_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pulse |=> mode_q != MODE_ALARM)
		else $error("restart pulse together with the alarm");

endmodule

`default_nettype wire

### hdl/endurance_cycle_controller.sv
// Endurance cycle controller: input register, one-pass update, result register.
// An accepted beat is held in the input register, then its result in the result register.
// Throughput: one beat per cycle while m_tready is high; the state update in ecc_core is one combinational pass.
// Reset (arst_n low) clears the state to idle, the counter and timer to zero,
// and loads the timeout registers with their defaults.
`default_nettype none

module endurance_cycle_controller #(
	parameter int COUNT_BITS = 24,
	parameter int TIMER_BITS = 25
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// Fields from bit 0: tick, play_press, preset_press, feedback_level; zero fill.
	input  wire  [ecc_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// Fields from bit 0: mode[2:0], drive_on, restart_pulse, buzzer_on, green_flash,
	// red_on, yellow_flash, cycle_count[23:0]; zero fill.
	output logic [ecc_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [ecc_pkg::APB_AW-1:0]        paddr,
	input  wire  [ecc_pkg::APB_DW-1:0]        pwdata,
	output logic [ecc_pkg::APB_DW-1:0]        prdata,
	output logic                              pready
);
	import ecc_pkg::*;

	localparam int PAD_W = OUT_TDATA_W - $bits(result_t);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_s2;
	logic    valid_s2;
	logic    adv;

	// A beat leaves the input register when the result register is free or draining.
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= item_t'(s_tdata[$bits(item_t)-1:0]);
		if (adv)
			result_s2 <= result;
	end

	ecc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ecc_core #(
		.COUNT_BITS (COUNT_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{PAD_W{1'b0}}, result_s2};

endmodule

`default_nettype wire
